// ===== src/superio_config_unlock_assert.svh =====
// assertion macros for the unlock logic
`ifndef SUPERIO_CONFIG_UNLOCK_ASSERT_SVH
`define SUPERIO_CONFIG_UNLOCK_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define SSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define SSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ssu_pkg.sv =====
// types, constants and key table for the config unlock block
package ssu_pkg;

    localparam int ADDR_W        = 10;
    localparam int BYTE_W        = 8;
    localparam int PHASE_W       = 2;
    localparam int KEY_ROM_DEPTH = 64;
    localparam int KEY_IDX_W     = 6;
    localparam int KEY_LENGTH_DEF = 32;

    localparam logic REQ_WRITE = 1'b1;

    localparam logic [ADDR_W-1:0] SELECT_PORT = 10'h279;
    localparam logic [BYTE_W-1:0] HEAD_BYTE0  = 8'h86;
    localparam logic [BYTE_W-1:0] HEAD_BYTE1  = 8'h80;

    localparam logic [2*BYTE_W-1:0] PAIR_A = 16'h5555;
    localparam logic [2*BYTE_W-1:0] PAIR_B = 16'h55aa;
    localparam logic [2*BYTE_W-1:0] PAIR_C = 16'haa55;

    localparam logic [ADDR_W-1:0] IDX_PORT_A = 10'h3f0;
    localparam logic [ADDR_W-1:0] DAT_PORT_A = 10'h3f1;
    localparam logic [ADDR_W-1:0] IDX_PORT_B = 10'h3bd;
    localparam logic [ADDR_W-1:0] DAT_PORT_B = 10'h3bf;
    localparam logic [ADDR_W-1:0] IDX_PORT_C = 10'h370;
    localparam logic [ADDR_W-1:0] DAT_PORT_C = 10'h371;

    localparam logic [BYTE_W-1:0] KEY_SEED = 8'h6a;

    localparam logic [BYTE_W-1:0] REG_LOCK     = 8'h02;
    localparam int                LOCK_BIT     = 1;
    localparam logic [BYTE_W-1:0] REG_CHIP_ID0 = 8'h20;
    localparam logic [BYTE_W-1:0] REG_CHIP_ID1 = 8'h21;
    localparam logic [BYTE_W-1:0] REG_CHIP_REV = 8'h22;
    localparam logic [BYTE_W-1:0] CHIP_ID0_VAL = 8'h86;
    localparam logic [BYTE_W-1:0] CHIP_ID1_VAL = 8'h81;
    localparam logic [BYTE_W-1:0] CHIP_REV_VAL = 8'h00;

    localparam logic [PHASE_W-1:0] PHASE_CODE_WAIT   = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_UNLOCK = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_OPEN   = 2'd2;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'b001,
        PH_UNLOCK = 3'b010,
        PH_OPEN   = 3'b100
    } phase_t;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] io_addr;
        logic [BYTE_W-1:0] wdata;
    } ssu_req_t;

    typedef struct packed {
        logic               claimed;
        logic [BYTE_W-1:0]  read_data;
        logic               bank_read;
        logic               bank_write;
        logic [BYTE_W-1:0]  bank_index;
        logic [BYTE_W-1:0]  bank_wdata;
        logic [PHASE_W-1:0] phase_now;
    } ssu_rsp_t;

    // pipeline flow between the stages
    typedef struct packed {
        logic valid;
        logic advance;
    } ssu_flow_t;

    typedef logic [BYTE_W-1:0] key_rom_t [KEY_ROM_DEPTH];

    // lfsr key sequence, new bit 7 = bit 0 xor bit 1, evaluated at elaboration
    function automatic key_rom_t gen_key_rom();
        key_rom_t          rom;
        logic [BYTE_W-1:0] v;
        v = KEY_SEED;
        for (int i = 0; i < KEY_ROM_DEPTH; i++)
        begin
            rom[i] = v;
            v = {v[0] ^ v[1], v[BYTE_W-1:1]};
        end
        return rom;
    endfunction

    localparam key_rom_t KEY_ROM = gen_key_rom();

endpackage

// ===== src/ssu_req_if.sv =====
// request channel: one i/o bus access per item
interface ssu_req_if;
    import ssu_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] io_addr;
    logic [BYTE_W-1:0] wdata;

    modport source (output valid, output req_type, output io_addr, output wdata,
                    input ready);
    modport sink   (input valid, input req_type, input io_addr, input wdata,
                    output ready);
endinterface

// ===== src/ssu_rsp_if.sv =====
// result channel: one decode result per item
interface ssu_rsp_if;
    import ssu_pkg::*;

    logic               valid;
    logic               ready;
    logic               claimed;
    logic [BYTE_W-1:0]  read_data;
    logic               bank_read;
    logic               bank_write;
    logic [BYTE_W-1:0]  bank_index;
    logic [BYTE_W-1:0]  bank_wdata;
    logic [PHASE_W-1:0] phase_now;

    modport source (output valid, output claimed, output read_data, output bank_read,
                    output bank_write, output bank_index, output bank_wdata,
                    output phase_now, input ready);
    modport sink   (input valid, input claimed, input read_data, input bank_read,
                    input bank_write, input bank_index, input bank_wdata,
                    input phase_now, output ready);
endinterface

// ===== src/ssu_in_reg.sv =====
// input register stage for request items
module ssu_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    ssu_req_if.sink          req,
    input  logic             advance,
    output ssu_pkg::ssu_req_t item,
    output logic             valid
);
    import ssu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ssu_req_t item_reg;
    logic     take;

    assign req.ready  = !valid_reg || advance;
    assign take       = req.valid && req.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{req_type: req.req_type, io_addr: req.io_addr,
                          wdata: req.wdata};
        end
    end

    assign item  = item_reg;
    assign valid = valid_reg;
endmodule

// ===== src/ssu_engine.sv =====
// unlock phase state and per-item decode
module ssu_engine #(
    parameter int KEY_LENGTH = ssu_pkg::KEY_LENGTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  ssu_pkg::ssu_req_t item,
    output ssu_pkg::ssu_rsp_t result
);
    import ssu_pkg::*;
    `include "superio_config_unlock_assert.svh"

    localparam int SEQ_W = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
    localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(KEY_LENGTH - 1);

    phase_t            phase_reg,     phase_next;
    logic [1:0]        pk_cnt_reg,    pk_cnt_next;
    logic [BYTE_W-1:0] pk_byte_reg [3];
    logic [SEQ_W-1:0]  seq_cnt_reg,   seq_cnt_next;
    logic              seq_mis_reg,   seq_mis_next;
    logic [BYTE_W-1:0] reg_index_reg, reg_index_next;
    logic [ADDR_W-1:0] index_port_reg, index_port_next;
    logic [ADDR_W-1:0] data_port_reg,  data_port_next;

    logic              wr;
    logic              is_idx;
    logic              is_dat;
    logic              wait_hit;
    logic              key_bad;
    logic              head_ok;
    logic              pair_ok;
    logic [ADDR_W-1:0] pair_idx;
    logic [ADDR_W-1:0] pair_dat;
    ssu_rsp_t          res;

    assign wr       = (item.req_type == REQ_WRITE);
    assign is_idx   = (item.io_addr == index_port_reg);
    assign is_dat   = (item.io_addr == data_port_reg);
    assign wait_hit = wr && (item.io_addr == SELECT_PORT);
    assign key_bad  = (item.wdata != KEY_ROM[KEY_IDX_W'(seq_cnt_reg)]);
    assign head_ok  = (pk_byte_reg[0] == HEAD_BYTE0) && (pk_byte_reg[1] == HEAD_BYTE1);

    // last two port key bytes pick the port pair
    always_comb
    begin
        pair_ok  = 1'b1;
        pair_idx = IDX_PORT_A;
        pair_dat = DAT_PORT_A;
        case ({pk_byte_reg[2], item.wdata})
            PAIR_A:
            begin
                pair_idx = IDX_PORT_A;
                pair_dat = DAT_PORT_A;
            end
            PAIR_B:
            begin
                pair_idx = IDX_PORT_B;
                pair_dat = DAT_PORT_B;
            end
            PAIR_C:
            begin
                pair_idx = IDX_PORT_C;
                pair_dat = DAT_PORT_C;
            end
            default:
            begin
                pair_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        pk_cnt_next     = pk_cnt_reg;
        seq_cnt_next    = seq_cnt_reg;
        seq_mis_next    = seq_mis_reg;
        reg_index_next  = reg_index_reg;
        index_port_next = index_port_reg;
        data_port_next  = data_port_reg;
        res             = '0;

        unique case (phase_reg)
            PH_UNLOCK:
            begin
                res.claimed = is_idx || is_dat;
                if (is_idx && wr)
                begin
                    if (seq_cnt_reg == SEQ_LAST)
                    begin
                        if (!(seq_mis_reg || key_bad))
                        begin
                            phase_next = PH_OPEN;
                        end
                        seq_cnt_next = '0;
                        seq_mis_next = 1'b0;
                    end
                    else
                    begin
                        seq_cnt_next = seq_cnt_reg + 1'b1;
                        seq_mis_next = seq_mis_reg || key_bad;
                    end
                end
            end
            PH_OPEN:
            begin
                res.claimed = is_idx || is_dat;
                if (is_idx)
                begin
                    if (wr)
                    begin
                        reg_index_next = item.wdata;
                    end
                    else
                    begin
                        res.read_data = reg_index_reg;
                    end
                end
                else if (is_dat)
                begin
                    if (wr)
                    begin
                        if (reg_index_reg == REG_LOCK)
                        begin
                            if (item.wdata[LOCK_BIT])
                            begin
                                phase_next   = PH_UNLOCK;
                                seq_cnt_next = '0;
                                seq_mis_next = 1'b0;
                            end
                        end
                        else
                        begin
                            res.bank_write = 1'b1;
                            res.bank_index = reg_index_reg;
                            res.bank_wdata = item.wdata;
                        end
                    end
                    else
                    begin
                        unique case (reg_index_reg)
                            REG_CHIP_ID0: res.read_data = CHIP_ID0_VAL;
                            REG_CHIP_ID1: res.read_data = CHIP_ID1_VAL;
                            REG_CHIP_REV: res.read_data = CHIP_REV_VAL;
                            default:
                            begin
                                res.bank_read  = 1'b1;
                                res.bank_index = reg_index_reg;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                if (wait_hit)
                begin
                    res.claimed = 1'b1;
                    pk_cnt_next = pk_cnt_reg + 1'b1;
                    if ((pk_cnt_reg == 2'd3) && head_ok && pair_ok)
                    begin
                        index_port_next = pair_idx;
                        data_port_next  = pair_dat;
                        phase_next      = PH_UNLOCK;
                        seq_cnt_next    = '0;
                        seq_mis_next    = 1'b0;
                    end
                end
            end
        endcase

        unique case (phase_next)
            PH_UNLOCK: res.phase_now = PHASE_CODE_UNLOCK;
            PH_OPEN:   res.phase_now = PHASE_CODE_OPEN;
            default:   res.phase_now = PHASE_CODE_WAIT;
        endcase
    end

    assign result = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT;
            pk_cnt_reg     <= '0;
            seq_cnt_reg    <= '0;
            seq_mis_reg    <= 1'b0;
            reg_index_reg  <= '0;
            index_port_reg <= IDX_PORT_A;
            data_port_reg  <= DAT_PORT_A;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            pk_cnt_reg     <= pk_cnt_next;
            seq_cnt_reg    <= seq_cnt_next;
            seq_mis_reg    <= seq_mis_next;
            reg_index_reg  <= reg_index_next;
            index_port_reg <= index_port_next;
            data_port_reg  <= data_port_next;
        end
    end

    // first three port key bytes, the fourth is taken live
    always_ff @(posedge clk)
    begin
        if (fire && (phase_reg == PH_WAIT) && wait_hit && (pk_cnt_reg != 2'd3))
        begin
            pk_byte_reg[pk_cnt_reg] <= item.wdata;
        end
    end

    `SSU_ASSERT_NOW(a_seq_idle, phase_reg != PH_UNLOCK,
        (seq_cnt_reg == '0) && !seq_mis_reg, "key sequence state live outside unlock")
    `SSU_ASSERT_NOW(a_bank_open, fire && (res.bank_read || res.bank_write),
        phase_reg == PH_OPEN, "bank access outside open phase")
    `SSU_ASSERT_NOW(a_relock, fire && (phase_reg == PH_OPEN) &&
        (res.phase_now == PHASE_CODE_UNLOCK),
        wr && is_dat && (reg_index_reg == REG_LOCK), "relock without lock register write")
    `SSU_ASSERT_NEXT(a_wait_hold, fire && (phase_reg == PH_WAIT) && !wait_hit,
        phase_reg == PH_WAIT, "wait phase left without select port write")
endmodule

// ===== src/ssu_out_reg.sv =====
// result register stage
module ssu_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  ssu_pkg::ssu_rsp_t result,
    output logic              free,
    ssu_rsp_if.source         rsp
);
    import ssu_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    ssu_rsp_t data_reg;

    assign free       = !valid_reg || rsp.ready;
    assign valid_next = load ? 1'b1 : (rsp.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.claimed    = data_reg.claimed;
    assign rsp.read_data  = data_reg.read_data;
    assign rsp.bank_read  = data_reg.bank_read;
    assign rsp.bank_write = data_reg.bank_write;
    assign rsp.bank_index = data_reg.bank_index;
    assign rsp.bank_wdata = data_reg.bank_wdata;
    assign rsp.phase_now  = data_reg.phase_now;
endmodule

// ===== src/superio_config_unlock.sv =====
// top level of the super i/o configuration unlock front end
// an accepted item is held in the input register, decoded, then loaded into the result register
// throughput: one item per cycle, no bubbles while the result side keeps taking items
// rate is set by the combinational decode between the input and result registers
// reset: rst_n low clears both stage valids and puts the block in the wait phase
// with ports 0x3f0/0x3f1, register index 0 and all key counters at zero
module superio_config_unlock #(
    parameter int KEY_LENGTH = ssu_pkg::KEY_LENGTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ssu_req_if.sink   req,
    ssu_rsp_if.source rsp
);
    import ssu_pkg::*;

    // key length must fit the precomputed key table
    if (KEY_LENGTH < 1 || KEY_LENGTH > KEY_ROM_DEPTH)
    begin : g_bad_key_length
        $error("KEY_LENGTH out of range");
    end

    ssu_flow_t flow;
    ssu_req_t  item;
    ssu_rsp_t  result;
    logic      out_free;

    // input register: holds the next access while the decode is stalled
    ssu_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (flow.advance),
        .item    (item),
        .valid   (flow.valid)
    );

    // an item moves into the result register whenever that register can take it;
    // the phase state commits at the same edge, so the next item sees it
    assign flow.advance = flow.valid && out_free;

    // phase machine, key compare and register decode
    ssu_engine #(
        .KEY_LENGTH (KEY_LENGTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (flow.advance),
        .item   (item),
        .result (result)
    );

    // result register: decouples the result side from the decode
    ssu_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (flow.advance),
        .result (result),
        .free   (out_free),
        .rsp    (rsp)
    );
endmodule

// ===== tb/superio_config_unlock_tb.sv =====
// testbench for the super i/o configuration unlock front end
module superio_config_unlock_tb;
    import ssu_pkg::*;

    // access kind: the package names only the write code
    localparam logic REQ_READ = ~REQ_WRITE;

    localparam int KEY_LEN       = KEY_LENGTH_DEF;
    localparam int RANDOM_ITEMS  = 850;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 200000;

    logic clk = 1'b0;
    logic rst_n;

    ssu_req_if req ();
    ssu_rsp_if rsp ();

    superio_config_unlock dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // period of two time units
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predicted block state, updated once per accepted item
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] exp_phase       = PHASE_CODE_WAIT;
    logic [1:0]         sel_count       = 2'd0;   // bytes seen at the select port
    logic [BYTE_W-1:0]  sel_bytes [4]   = '{default: '0};
    int                 key_pos         = 0;      // position in the initiation key
    bit                 key_bad         = 1'b0;   // a key byte has mismatched
    logic [BYTE_W-1:0]  exp_reg_index   = '0;
    logic [ADDR_W-1:0]  exp_index_port  = IDX_PORT_A;
    logic [ADDR_W-1:0]  exp_data_port   = DAT_PORT_A;

    // decode results still owed by the block, oldest first
    ssu_rsp_t pending_decodes [$];

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  burst_left    = 0;
    bit  no_gaps       = 1'b0;
    int  hold_requests = 0;
    int  cycle_count   = 0;

    // byte n of the initiation key: 8-bit lfsr, new msb = bit 0 xor bit 1
    function automatic logic [BYTE_W-1:0] unlock_key_byte(input int n);
        logic [BYTE_W-1:0] v;
        v = KEY_SEED;
        for (int i = 0; i < n; i++)
        begin
            v = {v[0] ^ v[1], v[BYTE_W-1:1]};
        end
        return v;
    endfunction

    // decode one bus access against the predicted state and advance that state
    function automatic ssu_rsp_t decode_access(input logic wr, input logic [ADDR_W-1:0] addr,
                                               input logic [BYTE_W-1:0] d);
        ssu_rsp_t          r;
        logic              is_idx;
        logic              is_dat;
        logic [15:0]       pair;
        bit                head_ok;
        logic [ADDR_W-1:0] ip;
        logic [ADDR_W-1:0] dp;
        bit                pair_ok;
        r = '0;
        if (exp_phase == PHASE_CODE_UNLOCK || exp_phase == PHASE_CODE_OPEN)
        begin
            is_idx    = (addr == exp_index_port);
            is_dat    = (addr == exp_data_port);
            r.claimed = is_idx | is_dat;
            if (exp_phase == PHASE_CODE_UNLOCK)
            begin
                // only index writes advance the key; data port is claimed but inert
                if (is_idx && wr == REQ_WRITE)
                begin
                    if (d != unlock_key_byte(key_pos))
                        key_bad = 1'b1;
                    key_pos++;
                    if (key_pos >= KEY_LEN)
                    begin
                        if (!key_bad)
                            exp_phase = PHASE_CODE_OPEN;
                        key_pos = 0;
                        key_bad = 1'b0;
                    end
                end
            end
            else if (is_idx)
            begin
                if (wr == REQ_WRITE)
                    exp_reg_index = d;
                else
                    r.read_data = exp_reg_index;
            end
            else if (is_dat)
            begin
                if (wr == REQ_WRITE)
                begin
                    // lock register writes never reach the bank
                    if (exp_reg_index == REG_LOCK)
                    begin
                        if (d[LOCK_BIT])
                        begin
                            exp_phase = PHASE_CODE_UNLOCK;
                            key_pos   = 0;
                            key_bad   = 1'b0;
                        end
                    end
                    else
                    begin
                        r.bank_write = 1'b1;
                        r.bank_index = exp_reg_index;
                        r.bank_wdata = d;
                    end
                end
                else if (exp_reg_index == REG_CHIP_ID0)
                    r.read_data = CHIP_ID0_VAL;
                else if (exp_reg_index == REG_CHIP_ID1)
                    r.read_data = CHIP_ID1_VAL;
                else if (exp_reg_index == REG_CHIP_REV)
                    r.read_data = CHIP_REV_VAL;
                else
                begin
                    r.bank_read  = 1'b1;
                    r.bank_index = exp_reg_index;
                end
            end
        end
        else if (wr == REQ_WRITE && addr == SELECT_PORT)
        begin
            // wait phase: collect four select bytes, judge them as a group
            r.claimed            = 1'b1;
            sel_bytes[sel_count] = d;
            sel_count            = sel_count + 2'd1;
            if (sel_count == 2'd0)
            begin
                pair    = {sel_bytes[2], sel_bytes[3]};
                head_ok = (sel_bytes[0] == HEAD_BYTE0) && (sel_bytes[1] == HEAD_BYTE1);
                pair_ok = 1'b1;
                ip      = '0;
                dp      = '0;
                if (pair == PAIR_A)
                begin
                    ip = IDX_PORT_A;
                    dp = DAT_PORT_A;
                end
                else if (pair == PAIR_B)
                begin
                    ip = IDX_PORT_B;
                    dp = DAT_PORT_B;
                end
                else if (pair == PAIR_C)
                begin
                    ip = IDX_PORT_C;
                    dp = DAT_PORT_C;
                end
                else
                    pair_ok = 1'b0;
                if (pair_ok && head_ok)
                begin
                    exp_index_port = ip;
                    exp_data_port  = dp;
                    exp_phase      = PHASE_CODE_UNLOCK;
                    key_pos        = 0;
                    key_bad        = 1'b0;
                end
            end
        end
        r.phase_now = exp_phase;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    task automatic send_access(input logic wr, input logic [ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (no_gaps)
                gap = 0;
            if (gap > 0)
            begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid    <= 1'b1;
        req.req_type <= wr;
        req.io_addr  <= addr;
        req.wdata    <= d;
        // item is taken at the first edge where ready is seen high
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        pending_decodes.push_back(decode_access(wr, addr, d));
        items_sent++;
    endtask

    // four select-port writes; the count is realigned first so the group lines up
    task automatic send_select_key(input logic [15:0] pair, input bit good_head);
        while (sel_count != 2'd0 && exp_phase == PHASE_CODE_WAIT)
            send_access(REQ_WRITE, SELECT_PORT, BYTE_W'($urandom_range(0, 255)));
        send_access(REQ_WRITE, SELECT_PORT, HEAD_BYTE0);
        send_access(REQ_WRITE, SELECT_PORT,
                    good_head ? HEAD_BYTE1 : HEAD_BYTE1 ^ BYTE_W'($urandom_range(1, 255)));
        send_access(REQ_WRITE, SELECT_PORT, pair[15:8]);
        send_access(REQ_WRITE, SELECT_PORT, pair[7:0]);
    endtask

    // rest of the initiation key from the current position; one byte may be
    // corrupted, and with mixed set uncounted accesses are slipped in between
    task automatic send_unlock_key(input int bad_pos, input bit mixed);
        int                start;
        logic [BYTE_W-1:0] d;
        start = key_pos;
        for (int i = start; i < KEY_LEN; i++)
        begin
            if (mixed && $urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: send_access(REQ_READ, exp_index_port, BYTE_W'($urandom_range(0, 255)));
                    1: send_access(REQ_READ, exp_data_port, BYTE_W'($urandom_range(0, 255)));
                    2: send_access(REQ_WRITE, exp_data_port, BYTE_W'($urandom_range(0, 255)));
                    default: send_access(REQ_WRITE, SELECT_PORT,
                                         BYTE_W'($urandom_range(0, 255)));
                endcase
            end
            d = unlock_key_byte(i);
            if (i == bad_pos)
                d = d ^ BYTE_W'($urandom_range(1, 255));
            send_access(REQ_WRITE, exp_index_port, d);
        end
    endtask

    // short run of unstructured accesses, weighted toward the decoded ports
    task automatic random_noise();
        int                n;
        logic [ADDR_W-1:0] a;
        logic [BYTE_W-1:0] d;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            case ($urandom_range(0, 6))
                0:       a = SELECT_PORT;
                1:       a = exp_index_port;
                2:       a = exp_data_port;
                3:       a = IDX_PORT_B;
                4:       a = DAT_PORT_C;
                default: a = ADDR_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 5))
                0:       d = HEAD_BYTE0;
                1:       d = HEAD_BYTE1;
                2:       d = PAIR_B[15:8];
                3:       d = PAIR_B[7:0];
                default: d = BYTE_W'($urandom_range(0, 255));
            endcase
            send_access(1'($urandom_range(0, 1)), a, d);
        end
    endtask

    // one access of the kind software makes with the space open, or a short noise run
    task automatic open_access();
        logic [BYTE_W-1:0] ri;
        case ($urandom_range(0, 15))
            0, 1, 2, 3:
            begin
                case ($urandom_range(0, 7))
                    0:       ri = REG_LOCK;
                    1:       ri = REG_CHIP_ID0;
                    2:       ri = REG_CHIP_ID1;
                    3:       ri = REG_CHIP_REV;
                    default: ri = BYTE_W'($urandom_range(0, 255));
                endcase
                send_access(REQ_WRITE, exp_index_port, ri);
            end
            4, 5, 6, 7:  send_access(REQ_READ, exp_data_port, BYTE_W'($urandom_range(0, 255)));
            8, 9, 10:    send_access(REQ_WRITE, exp_data_port, BYTE_W'($urandom_range(0, 255)));
            11, 12:      send_access(REQ_READ, exp_index_port, BYTE_W'($urandom_range(0, 255)));
            13:          send_access(REQ_WRITE, SELECT_PORT, BYTE_W'($urandom_range(0, 255)));
            default:     random_noise();
        endcase
    endtask

    // pick the next sequence by the predicted phase: mostly well formed
    task automatic random_action();
        logic [15:0] pairs [3];
        int unsigned r;
        pairs = '{PAIR_A, PAIR_B, PAIR_C};
        r     = $urandom_range(0, 9);
        case (exp_phase)
            PHASE_CODE_WAIT:
                if (r < 3)
                    random_noise();
                else if (r == 3)
                    send_select_key(16'($urandom_range(0, 65535)), 1'b1);
                else
                    send_select_key(pairs[$urandom_range(0, 2)], r != 4);
            PHASE_CODE_UNLOCK:
                if (r < 2)
                    random_noise();
                else
                    send_unlock_key((r == 2) ? $urandom_range(0, KEY_LEN - 1) : -1, 1'b1);
            default:
                if (r == 0)
                    random_noise();
                else
                    open_access();
        endcase
    endtask

    // ------------------------------------------------------------------
    // result side: ready on a self-chosen pattern, plus long hold-offs on demand
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int mode;
        int mode_left;
        int pat;
        int hold_left;
        int hold_seen;
        mode      = 0;
        mode_left = 0;
        pat       = 0;
        hold_left = 0;
        hold_seen = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(32, 200);
                end
                mode_left--;
                pat++;
                case (mode)
                    0:       rsp.ready <= 1'b1;                     // no stalls
                    1:       rsp.ready <= (pat % 5) < 3;            // fixed duty pattern
                    default: rsp.ready <= 1'($urandom_range(0, 1)); // coin flip
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // every result taken is matched against the oldest prediction
    always @(posedge clk)
    begin : result_check
        ssu_rsp_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("result item with no access outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                check_field("claimed", 16'(want.claimed), 16'(rsp.claimed));
                check_field("read_data", 16'(want.read_data), 16'(rsp.read_data));
                check_field("bank_read", 16'(want.bank_read), 16'(rsp.bank_read));
                check_field("bank_write", 16'(want.bank_write), 16'(rsp.bank_write));
                check_field("bank_index", 16'(want.bank_index), 16'(rsp.bank_index));
                check_field("bank_wdata", 16'(want.bank_wdata), 16'(rsp.bank_wdata));
                check_field("phase_now", 16'(want.phase_now), 16'(rsp.phase_now));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // wait phase: reads, wrong ports, extremes, select groups that must not open
    task automatic test_wait_phase();
        send_access(REQ_READ, SELECT_PORT, 8'h00);          // select port is write only
        send_access(REQ_READ, 10'h000, 8'hff);
        send_access(REQ_WRITE, 10'h3ff, 8'hff);
        send_access(REQ_WRITE, IDX_PORT_A, unlock_key_byte(0));
        send_access(REQ_READ, DAT_PORT_A, 8'h00);
        send_select_key(PAIR_A, 1'b0);                      // bad head byte
        send_select_key(PAIR_B ^ 16'h0001, 1'b1);           // good head, bad pair
        send_select_key(PAIR_C, 1'b0);
    endtask

    // random traffic while still waiting for a select group
    task automatic test_wait_noise();
        repeat (15)
            random_noise();
    endtask

    // one good select group, pair picked at random; only one can ever take
    task automatic test_port_select();
        logic [15:0] pairs [3];
        pairs = '{PAIR_A, PAIR_B, PAIR_C};
        send_select_key(pairs[$urandom_range(0, 2)], 1'b1);
    endtask

    // unlock phase: inert ports, keys failing on their last and first byte, then a good key
    task automatic test_unlock_phase();
        send_access(REQ_WRITE, SELECT_PORT, HEAD_BYTE0);    // ignored outside wait
        send_access(REQ_READ, exp_data_port, 8'h00);
        send_access(REQ_WRITE, exp_data_port, 8'hff);
        send_access(REQ_READ, exp_index_port, 8'h00);       // not counted
        send_unlock_key(KEY_LEN - 1, 1'b0);
        send_unlock_key(0, 1'b0);                           // first byte wrong
        send_unlock_key(-1, 1'b1);
    endtask

    // open phase: index register, chip id, bank traffic, lock register bit clear
    task automatic test_open_phase();
        send_access(REQ_READ, exp_index_port, 8'h00);
        send_access(REQ_WRITE, exp_index_port, REG_CHIP_ID0);
        send_access(REQ_READ, exp_data_port, 8'h00);
        send_access(REQ_WRITE, exp_index_port, REG_CHIP_ID1);
        send_access(REQ_READ, exp_data_port, 8'h00);
        send_access(REQ_WRITE, exp_data_port, 8'h5a);       // chip id writes go to the bank
        send_access(REQ_WRITE, exp_index_port, REG_CHIP_REV);
        send_access(REQ_READ, exp_data_port, 8'h00);
        send_access(REQ_WRITE, exp_index_port, 8'hff);
        send_access(REQ_READ, exp_data_port, 8'h00);
        send_access(REQ_WRITE, exp_data_port, 8'h00);
        send_access(REQ_READ, exp_index_port, 8'h00);
        send_access(REQ_WRITE, exp_index_port, REG_LOCK);
        send_access(REQ_WRITE, exp_data_port, 8'hfd);       // lock bit clear: nothing
        send_access(REQ_WRITE, SELECT_PORT, HEAD_BYTE0);
        send_access(REQ_READ, 10'h3ff, 8'h00);
    endtask

    // lock bit set drops back to unlock; a fresh key opens again
    task automatic test_relock();
        send_access(REQ_WRITE, exp_data_port, 8'h02);
        send_access(REQ_READ, exp_data_port, 8'h00);
        send_access(REQ_READ, exp_index_port, 8'h00);
        send_unlock_key(-1, 1'b0);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_input_stall();
        hold_requests++;
        no_gaps = 1'b1;
        repeat (30)
            random_action();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_traffic();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
            random_action();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        req.valid    <= 1'b0;
        req.req_type <= REQ_READ;
        req.io_addr  <= '0;
        req.wdata    <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_wait_phase();
        test_wait_noise();
        test_port_select();
        test_unlock_phase();
        test_open_phase();
        test_relock();
        test_input_stall();
        test_random_traffic();
        test_input_stall();

        req.valid <= 1'b0;
        // drain, then leave room for anything still in the pipe
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== superio_config_unlock.f =====
+incdir+src
src/ssu_pkg.sv
src/ssu_req_if.sv
src/ssu_rsp_if.sv
src/ssu_in_reg.sv
src/ssu_engine.sv
src/ssu_out_reg.sv
src/superio_config_unlock.sv
tb/superio_config_unlock_tb.sv
